// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the validator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/dcsv_pkg.sv =====
// Types and constants of the draw command stream validator.
// No dependencies; imported by the top level, the parser and the output buffer.
package dcsv_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [31:0] STREAM_MAGIC   = 32'h4458_3131;
    localparam logic [31:0] STREAM_VERSION = 32'd1;
    localparam logic [31:0] REC_BASE_WORDS = 32'd8;
    localparam logic [7:0]  ALPHA_FULL     = 8'hff;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RECT  = 2'd2;
    localparam logic [1:0] OP_IMAGE = 2'd3;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_RECORD  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // Word positions inside the header.
    localparam logic [2:0] HDR_MAGIC   = 3'd0;
    localparam logic [2:0] HDR_VERSION = 3'd1;
    localparam logic [2:0] HDR_COUNT   = 3'd2;
    localparam logic [2:0] HDR_TOTAL   = 3'd3;

    // Word positions inside a record.
    localparam logic [2:0] REC_OP      = 3'd0;
    localparam logic [2:0] REC_LENGTH  = 3'd1;
    localparam logic [2:0] REC_X       = 3'd2;
    localparam logic [2:0] REC_Y       = 3'd3;
    localparam logic [2:0] REC_W       = 3'd4;
    localparam logic [2:0] REC_H       = 3'd5;
    localparam logic [2:0] REC_ARG     = 3'd6;
    localparam logic [2:0] REC_PAYLOAD = 3'd7;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
    } t_frame_cfg;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_result;

endpackage

// ===== rtl/draw_command_stream_validator.sv =====
// Top level of the draw command stream validator.
// Depends on dcsv_pkg, dcsv_parser and dcsv_out_fifo.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one stream word per
// transaction: its low 32 bits, a flag for nonzero upper bits and a last-word
// mark. The output channel (o_out_valid / i_out_stall) carries one verdict per
// stream, o_stream_ok, produced by the transaction that carries the last word.
// Words without the last-word mark produce no output transaction.
// Each word is checked in the cycle it is accepted; the verdict is written into
// a two-entry result buffer, from whose registers it is offered; one word is
// taken per cycle while the input is not stalled.
// A stalled receiver does not slow the input until both buffer entries hold
// verdicts; the input is then stalled until an entry is taken.
// The frame size registers are written through i_cfg_wr_en, i_cfg_index and
// i_cfg_data; the user must do so only while no stream is in progress, which the
// block does not enforce. Writes to unknown indices are ignored. Reset sets the
// frame to 1 by 1 pixel, empties the result buffer and returns the parser to the
// header start; after each verdict the parser returns there, frame size kept.
module draw_command_stream_validator import dcsv_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [31:0]               i_word_value,
    input  logic                      i_upper_nonzero,
    input  logic                      i_last_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_stream_ok,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_frame_cfg r_frame;
    t_result    result;
    logic       accept;
    logic       full;

    // The stall is taken straight from the buffer fill state, never from valid.
    assign o_in_stall = full;
    assign accept     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame.width  <= 16'd1;
            r_frame.height <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame.width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcsv_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_word_value   (i_word_value),
        .i_upper_nonzero(i_upper_nonzero),
        .i_last_word    (i_last_word),
        .i_frame        (r_frame),
        .o_result       (result)
    );

    dcsv_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_stream_ok(o_stream_ok),
        .o_full     (full)
    );

endmodule

// ===== rtl/dcsv_parser.sv =====
// Stream parser of the validator: header and record state, checks and verdict.
// Depends on dcsv_pkg.
module dcsv_parser import dcsv_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_word_value,
    input  logic        i_upper_nonzero,
    input  logic        i_last_word,
    input  t_frame_cfg  i_frame,
    output t_result     o_result
);

    localparam int CW = COUNT_BITS + 1;

    logic [CW-1:0] r_word_count, n_word_count;
    logic [31:0]   r_hdr_count, n_hdr_count;
    logic [31:0]   r_hdr_total, n_hdr_total;
    logic [31:0]   r_cmds_done, n_cmds_done;
    logic [1:0]    r_phase, n_phase;
    logic [2:0]    r_slot, n_slot;
    logic [1:0]    r_op, n_op;
    logic [31:0]   r_rec_len, n_rec_len;
    logic [31:0]   r_rect_x, n_rect_x;
    logic [31:0]   r_rect_y, n_rect_y;
    logic [31:0]   r_rect_w, n_rect_w;
    logic [31:0]   r_rect_h, n_rect_h;
    logic          r_arg_nz, n_arg_nz;
    logic [31:0]   r_payload_left, n_payload_left;
    logic          r_failed, n_failed;
    logic [31:0]   r_area;

    logic [31:0] frame_w;
    logic [31:0] frame_h;
    logic        rect_ok;
    logic        first;
    logic        len_bad;
    logic        rec_bad;
    logic [31:0] cmds_inc;
    logic        ok;

    assign frame_w  = {16'd0, i_frame.width};
    assign frame_h  = {16'd0, i_frame.height};
    assign cmds_inc = r_cmds_done + 32'd1;
    assign first    = (r_cmds_done == 32'd0);

    assign rect_ok = (r_rect_w != 32'd0) && (r_rect_h != 32'd0) &&
                     (r_rect_x <= frame_w) && (r_rect_y <= frame_h) &&
                     (r_rect_w <= frame_w - r_rect_x) && (r_rect_h <= frame_h - r_rect_y);

    assign len_bad = (r_rec_len < REC_BASE_WORDS) ||
                     (r_rec_len != i_word_value + REC_BASE_WORDS);

    // A rectangle inside the frame has both sides below 2^16, so the 16x16
    // product held in r_area is exact whenever it matters.
    always_comb begin
        case (r_op)
            OP_CLEAR: begin
                rec_bad = (r_rec_len != REC_BASE_WORDS) || (i_word_value != 32'd0) ||
                          ((r_rect_x | r_rect_y | r_rect_w | r_rect_h) != 32'd0);
            end
            OP_RECT: begin
                rec_bad = (r_rec_len != REC_BASE_WORDS) || (i_word_value != 32'd0) ||
                          !rect_ok || first;
            end
            OP_IMAGE: begin
                rec_bad = r_arg_nz || !rect_ok || (r_area != i_word_value) ||
                          (first && ((r_rect_x != 32'd0) || (r_rect_y != 32'd0) ||
                                     (r_rect_w != frame_w) || (r_rect_h != frame_h)));
            end
            default: begin
                rec_bad = 1'b1;
            end
        endcase
        rec_bad = rec_bad || len_bad;
    end

    always_comb begin
        n_word_count   = r_word_count;
        n_hdr_count    = r_hdr_count;
        n_hdr_total    = r_hdr_total;
        n_cmds_done    = r_cmds_done;
        n_phase        = r_phase;
        n_slot         = r_slot;
        n_op           = r_op;
        n_rec_len      = r_rec_len;
        n_rect_x       = r_rect_x;
        n_rect_y       = r_rect_y;
        n_rect_w       = r_rect_w;
        n_rect_h       = r_rect_h;
        n_arg_nz       = r_arg_nz;
        n_payload_left = r_payload_left;
        n_failed       = r_failed;
        ok             = 1'b0;

        if (i_accept) begin
            if (!r_word_count[COUNT_BITS]) begin
                n_word_count = r_word_count + CW'(1);
            end
            n_failed = r_failed | i_upper_nonzero;
            if (!n_failed) begin
                case (r_phase)
                    PH_HEADER: begin
                        case (r_slot)
                            HDR_MAGIC: begin
                                if (i_word_value != STREAM_MAGIC) n_failed = 1'b1;
                            end
                            HDR_VERSION: begin
                                if (i_word_value != STREAM_VERSION) n_failed = 1'b1;
                            end
                            HDR_COUNT: begin
                                n_hdr_count = i_word_value;
                                if (i_word_value == 32'd0) n_failed = 1'b1;
                            end
                            default: begin
                                n_hdr_total = i_word_value;
                            end
                        endcase
                        if (r_slot >= HDR_TOTAL) begin
                            n_slot  = HDR_MAGIC;
                            n_phase = PH_RECORD;
                        end else begin
                            n_slot = r_slot + 3'd1;
                        end
                    end
                    PH_RECORD: begin
                        case (r_slot)
                            REC_OP: begin
                                if (i_word_value == {30'd0, OP_CLEAR} ||
                                    i_word_value == {30'd0, OP_RECT} ||
                                    i_word_value == {30'd0, OP_IMAGE}) begin
                                    n_op = i_word_value[1:0];
                                end else begin
                                    n_op     = OP_NONE;
                                    n_failed = 1'b1;
                                end
                            end
                            REC_LENGTH: n_rec_len = i_word_value;
                            REC_X:      n_rect_x  = i_word_value;
                            REC_Y:      n_rect_y  = i_word_value;
                            REC_W:      n_rect_w  = i_word_value;
                            REC_H:      n_rect_h  = i_word_value;
                            REC_ARG:    n_arg_nz  = (i_word_value != 32'd0);
                            default: begin
                            end
                        endcase
                        if (r_slot == REC_PAYLOAD) begin
                            if (rec_bad) begin
                                n_failed = 1'b1;
                            end else if (i_word_value != 32'd0) begin
                                n_payload_left = i_word_value;
                                n_phase        = PH_PAYLOAD;
                            end else begin
                                n_cmds_done = cmds_inc;
                                n_slot      = REC_OP;
                                n_phase     = (cmds_inc == r_hdr_count) ? PH_DONE : PH_RECORD;
                            end
                        end else begin
                            n_slot = r_slot + 3'd1;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (i_word_value[31:24] != ALPHA_FULL) begin
                            n_failed = 1'b1;
                        end else begin
                            n_payload_left = r_payload_left - 32'd1;
                            if (r_payload_left == 32'd1) begin
                                n_cmds_done = cmds_inc;
                                n_slot      = REC_OP;
                                n_phase     = (cmds_inc == r_hdr_count) ? PH_DONE : PH_RECORD;
                            end
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end

            if (i_last_word) begin
                ok = !n_failed && (n_phase == PH_DONE) && !n_word_count[COUNT_BITS] &&
                     ({1'b0, n_hdr_total} == 33'(n_word_count));
                n_word_count   = '0;
                n_hdr_count    = '0;
                n_hdr_total    = '0;
                n_cmds_done    = '0;
                n_phase        = PH_HEADER;
                n_slot         = HDR_MAGIC;
                n_op           = OP_NONE;
                n_rec_len      = '0;
                n_rect_x       = '0;
                n_rect_y       = '0;
                n_rect_w       = '0;
                n_rect_h       = '0;
                n_arg_nz       = 1'b0;
                n_payload_left = '0;
                n_failed       = 1'b0;
            end
        end
    end

    assign o_result.valid = i_accept & i_last_word;
    assign o_result.ok    = ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count   <= '0;
            r_hdr_count    <= '0;
            r_hdr_total    <= '0;
            r_cmds_done    <= '0;
            r_phase        <= PH_HEADER;
            r_slot         <= HDR_MAGIC;
            r_op           <= OP_NONE;
            r_rec_len      <= '0;
            r_rect_x       <= '0;
            r_rect_y       <= '0;
            r_rect_w       <= '0;
            r_rect_h       <= '0;
            r_arg_nz       <= 1'b0;
            r_payload_left <= '0;
            r_failed       <= 1'b0;
        end else begin
            r_word_count   <= n_word_count;
            r_hdr_count    <= n_hdr_count;
            r_hdr_total    <= n_hdr_total;
            r_cmds_done    <= n_cmds_done;
            r_phase        <= n_phase;
            r_slot         <= n_slot;
            r_op           <= n_op;
            r_rec_len      <= n_rec_len;
            r_rect_x       <= n_rect_x;
            r_rect_y       <= n_rect_y;
            r_rect_w       <= n_rect_w;
            r_rect_h       <= n_rect_h;
            r_arg_nz       <= n_arg_nz;
            r_payload_left <= n_payload_left;
            r_failed       <= n_failed;
        end
    end

    // The height is stored at least two transactions before the payload length
    // word, so the area registered every cycle is current when it is compared.
    always_ff @(posedge i_clk) begin
        r_area <= r_rect_w[15:0] * r_rect_h[15:0];
    end

endmodule

// ===== rtl/dcsv_out_fifo.sv =====
// Two-entry result buffer that decouples the parser from the receiver.
// Depends on dcsv_pkg.
module dcsv_out_fifo import dcsv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output logic    o_stream_ok,
    output logic    o_full
);

    logic       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_out_valid = (r_count != 2'd0);
    assign o_stream_ok = r_data[r_rd_ptr];
    assign o_full      = (r_count == 2'd2);
    assign pop         = o_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_result.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_result.valid, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_data[r_wr_ptr] <= i_result.ok;
        end
    end

endmodule

// ===== rtl/dcsv_checker.sv =====
// Port-level checker of the validator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dcsv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_last_word,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_stream_ok
);

    logic in_acc;
    logic last_acc;

    assign in_acc   = i_in_valid & ~o_in_stall;
    assign last_acc = in_acc & i_last_word;

    // A verdict that is stalled stays offered and unchanged.
    `ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_ok_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_stream_ok))

    // A verdict only appears after a last word has been taken.
    `ASSERT_IMPLY(a_verdict_after_last, i_clk, i_rst_n, $rose(o_out_valid), $past(last_acc))

    // A last word taken with nothing pending is offered in the next cycle.
    `ASSERT_NEXT(a_last_gives_verdict, i_clk, i_rst_n, last_acc && !o_out_valid, o_out_valid)

endmodule

bind draw_command_stream_validator dcsv_checker u_checker (.*);
